/* hw/rtl/ipc_pkg.sv */
// Shared types, constants and the factorial table for the integer property classifier.
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

  localparam int VALUE_W    = 31;   // width of the tested integer
  localparam int OPW        = 36;   // width of the shared compare/subtract unit
  localparam int SQ_STEPS   = 16;   // square root: two value bits per step
  localparam int CUBE_STEPS = 11;   // cube root: three value bits per step
  localparam int FACT_COUNT = 12;   // 1! .. 12!, 13! does not fit in 31 bits
  localparam int CNT_W      = 4;
  localparam int CUBE_SH0   = 30;   // first shift of the cube root trial term

  typedef enum logic [1:0] {
    PROP_FIB    = 2'd0,
    PROP_SQUARE = 2'd1,
    PROP_CUBE   = 2'd2,
    PROP_FACT   = 2'd3
  } prop_t;

  typedef struct packed {
    logic [OPW-1:0] diff;   // a - b, valid when ge
    logic           ge;     // a >= b
    logic           eq;     // a == b
  } ipc_cmp_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic matched;
  } ipc_status_t;

  function automatic logic [31:0] fact_value(input logic [CNT_W-1:0] idx);
    logic [31:0] f;
    case (idx)
      4'd0:    f = 32'd1;
      4'd1:    f = 32'd2;
      4'd2:    f = 32'd6;
      4'd3:    f = 32'd24;
      4'd4:    f = 32'd120;
      4'd5:    f = 32'd720;
      4'd6:    f = 32'd5040;
      4'd7:    f = 32'd40320;
      4'd8:    f = 32'd362880;
      4'd9:    f = 32'd3628800;
      4'd10:   f = 32'd39916800;
      4'd11:   f = 32'd479001600;
      default: f = 32'hFFFF_FFFF;   // never equals a 31-bit value
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ipc_cmp.sv */
// Shared compare/subtract unit used by every property test.
`timescale 1ns / 1ps
`default_nettype none

module ipc_cmp import ipc_pkg::*; (
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  output ipc_cmp_t       res
);

  logic [OPW:0] diff_full;

  assign diff_full = {1'b0, a} - {1'b0, b};
  assign res.diff  = diff_full[OPW-1:0];
  assign res.ge    = ~diff_full[OPW];
  assign res.eq    = (a == b);

endmodule

`default_nettype wire

/* hw/rtl/ipc_core.sv */
// Step sequencer for the Fibonacci, square root, cube root and factorial tests.
`timescale 1ns / 1ps
`default_nettype none

module ipc_core import ipc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  prop_t              sel_in,
  input  logic [VALUE_W-1:0] value,
  input  logic               take,
  output ipc_status_t        status
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t             state;
  prop_t              sel;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] rem;      // square/cube remainder
  logic [31:0]        acc;      // fib lo, square root accumulator
  logic [32:0]        aux;      // fib hi, square root bit
  logic [10:0]        y;        // partial cube root
  logic [4:0]         sh;       // cube trial shift
  logic               matched;

  logic [11:0]        y2;
  logic [12:0]        y2p1;
  logic [24:0]        prod;
  logic [26:0]        trial;
  logic [OPW-1:0]     op_a;
  logic [OPW-1:0]     op_b;
  logic [VALUE_W-1:0] rem_next;
  ipc_cmp_t           cmp;

  // cube step: trial = (3*y2*(y2+1) + 1) << sh, with y2 = 2*y
  assign y2    = {y, 1'b0};
  assign y2p1  = {1'b0, y2} + 13'd1;
  assign prod  = y2 * y2p1;
  assign trial = {1'b0, prod, 1'b0} + {2'b00, prod} + 27'd1;

  always_comb begin
    unique case (sel)
      PROP_FIB: begin
        op_a = OPW'(value);
        op_b = OPW'(acc);
      end
      PROP_SQUARE: begin
        op_a = OPW'(rem);
        op_b = OPW'({1'b0, acc} + aux);
      end
      PROP_CUBE: begin
        op_a = OPW'(rem);
        op_b = OPW'(trial) << sh;
      end
      PROP_FACT: begin
        op_a = OPW'(value);
        op_b = OPW'(fact_value(cnt));
      end
    endcase
  end

  ipc_cmp u_cmp (
    .a   (op_a),
    .b   (op_b),
    .res (cmp)
  );

  assign rem_next = cmp.ge ? cmp.diff[VALUE_W-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= PROP_FIB;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state   <= S_RUN;
            sel     <= sel_in;
            cnt     <= '0;
            rem     <= value;
            acc     <= '0;
            aux     <= (sel_in == PROP_FIB) ? 33'd1 : 33'h0_4000_0000;
            y       <= '0;
            sh      <= 5'(CUBE_SH0);
            matched <= 1'b0;
          end
        end
        S_RUN: begin
          unique case (sel)
            PROP_FIB: begin
              if (cmp.eq) begin
                matched <= 1'b1;
                state   <= S_DONE;
              end else if (!cmp.ge) begin
                // term passed the value
                state <= S_DONE;
              end else begin
                acc <= aux[31:0];
                aux <= {1'b0, acc} + aux;
              end
            end
            PROP_SQUARE: begin
              rem <= rem_next;
              acc <= cmp.ge ? (acc >> 1) + aux[31:0] : acc >> 1;
              aux <= aux >> 2;
              cnt <= cnt + 1'b1;
              if (cnt == CNT_W'(SQ_STEPS - 1)) begin
                matched <= (rem_next == '0);
                state   <= S_DONE;
              end
            end
            PROP_CUBE: begin
              rem <= rem_next;
              y   <= {y2[10:1], cmp.ge};
              sh  <= sh - 5'd3;
              cnt <= cnt + 1'b1;
              if (cnt == CNT_W'(CUBE_STEPS - 1)) begin
                matched <= (rem_next == '0);
                state   <= S_DONE;
              end
            end
            PROP_FACT: begin
              if (cmp.eq) begin
                matched <= 1'b1;
                state   <= S_DONE;
              end else if (cnt == CNT_W'(FACT_COUNT - 1)) begin
                state <= S_DONE;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
          endcase
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.idle    = (state == S_IDLE);
  assign status.done    = (state == S_DONE);
  assign status.matched = matched;

endmodule

`default_nettype wire

/* hw/rtl/integer_property_classifier.sv */
// Top level: stream ports, property register, item hold and output register.
//
//   channel   dir  handshake                    payload
//   s_axis    in   tvalid / tready              tdata[30:0] value, tlast last_item
//   m_axis    out  tvalid / tready              tdata[30:0] value_echo, tuser matched,
//                                               tlast end_of_list
//   cfg       in   cfg_we (no wait)             cfg_wdata property_select
//
// One item occupies the step sequencer for: Fibonacci 1 to 48 steps (one term per
// cycle), square 16 steps, cube 11 steps, factorial 1 to 12 table compares.
// From the done state the result moves to the output register once that is free; the
// sequencer then returns to idle and accepts the next input, so items never overlap.
// All steps go through one shared compare/subtract unit.
// rst is synchronous; it clears the sequencer, the output valid and property_select.
// A result waiting on m_axis does not block the next input transfer; the sequencer
// holds its finished result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module integer_property_classifier import ipc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [30:0] value, [31] zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [30:0] value_echo, [31] zero pad
  output logic        m_axis_tuser,    // [0] matched
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata        // property_select
);

  prop_t              prop_sel;
  logic [VALUE_W-1:0] item_value;
  logic               item_last;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               out_matched;
  logic               out_last;
  logic               in_xfer;
  logic               out_load;
  ipc_status_t        status;

  assign s_axis_tready = status.idle;
  assign in_xfer       = s_axis_tvalid && status.idle;
  assign out_load      = status.done && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_sel <= PROP_FIB;
    end else if (cfg_we) begin
      prop_sel <= prop_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_value <= s_axis_tdata[VALUE_W-1:0];
      item_last  <= s_axis_tlast;
    end
  end

  ipc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (in_xfer),
    .sel_in (prop_sel),
    .value  (in_xfer ? s_axis_tdata[VALUE_W-1:0] : item_value),
    .take   (out_load),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        out_value   <= item_value;
        out_matched <= status.matched;
        out_last    <= item_last;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_value};
  assign m_axis_tuser  = out_matched;
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

/* hw/rtl/ipc_checker.sv */
// Port-level checks for the integer property classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        m_axis_tuser,
  input wire        m_axis_tlast
);

  // the sequencer is busy in the cycle after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted back to back");

  // no result can appear in the cycle right after an input transfer
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // one has every tested property
  a_one_matches: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[30:0] == 31'd1) |-> m_axis_tuser)
    else $error("value one not matched");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind integer_property_classifier ipc_checker u_ipc_checker (.*);

`default_nettype wire

/* verif/tb_top.sv */
// Testbench for integer_property_classifier: directed probes and random stream traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import ipc_pkg::*;

  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  DRAIN_CYCLES = 64;        // longest item plus margin
  localparam int  RAND_PHASES  = 10;
  localparam int  PHASE_ITEMS  = 140;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [30:0] value;
    logic        matched;
    logic        last;
  } verdict_t;

  typedef struct packed {
    prop_t       prop;
    logic [30:0] value;
  } probe_t;

  // Expected verdicts in transfer order, plus a private copy of property_select.
  class verdict_scoreboard;
    prop_t    prop;
    verdict_t verdicts[$];
    int       errors;

    function new();
      prop   = PROP_FIB;
      errors = 0;
    endfunction

    function bit is_fibonacci(logic [30:0] v);
      longint a, b, t;
      a = 0;
      b = 1;
      while (a <= longint'(v)) begin
        if (a == longint'(v)) return 1'b1;
        t = a + b;
        a = b;
        b = t;
      end
      return 1'b0;
    endfunction

    // Largest r in [0, top] with r^pow <= v, then exact compare.
    function bit is_power(logic [30:0] v, int pow, longint top);
      longint lo, hi, mid, p;
      lo = 0;
      hi = top;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        p = (pow == 2) ? mid * mid : mid * mid * mid;
        if (p <= longint'(v)) lo = mid;
        else hi = mid - 1;
      end
      p = (pow == 2) ? lo * lo : lo * lo * lo;
      return p == longint'(v);
    endfunction

    function bit is_factorial(logic [30:0] v);
      longint f;
      f = 1;
      for (int n = 1; n <= 12; n++) begin
        f = f * n;
        if (f == longint'(v)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [30:0] v, logic last);
      verdict_t e;
      e.value = v;
      e.last  = last;
      case (prop)
        PROP_FIB:    e.matched = is_fibonacci(v);
        PROP_SQUARE: e.matched = is_power(v, 2, 46341);
        PROP_CUBE:   e.matched = is_power(v, 3, 1291);
        default:     e.matched = is_factorial(v);
      endcase
      verdicts.push_back(e);
    endfunction

    function void check_result(logic [31:0] data, logic user, logic last);
      verdict_t e;
      if (verdicts.size() == 0) begin
        $error("unexpected output transfer: value_echo %0d", data[30:0]);
        errors++;
        return;
      end
      e = verdicts.pop_front();
      if (data[30:0] !== e.value) begin
        $error("value_echo: expected %0d, actual %0d", e.value, data[30:0]);
        errors++;
      end
      if (data[31] !== 1'b0) begin
        $error("tdata pad: expected 0, actual %b", data[31]);
        errors++;
      end
      if (user !== e.matched) begin
        $error("matched: expected %b, actual %b (value %0d)", e.matched, user, e.value);
        errors++;
      end
      if (last !== e.last) begin
        $error("end_of_list: expected %b, actual %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  verdict_scoreboard sb;
  bit tx_gaps_on;
  bit rx_stalls_on;
  int stall_left;
  int cycle_count;

  probe_t probes [23] = '{
    '{PROP_FIB, 31'd0}, '{PROP_FIB, 31'd1}, '{PROP_FIB, 31'd2}, '{PROP_FIB, 31'd4},
    '{PROP_FIB, 31'd1836311903}, '{PROP_FIB, 31'd1836311904}, '{PROP_FIB, VALUE_MAX},
    '{PROP_SQUARE, 31'd0}, '{PROP_SQUARE, 31'd2147395600}, '{PROP_SQUARE, 31'd2147395599},
    '{PROP_SQUARE, VALUE_MAX}, '{PROP_SQUARE, 31'd15},
    '{PROP_CUBE, 31'd0}, '{PROP_CUBE, 31'd1}, '{PROP_CUBE, 31'd2146689000},
    '{PROP_CUBE, 31'd2146689001}, '{PROP_CUBE, 31'd26},
    '{PROP_FACT, 31'd0}, '{PROP_FACT, 31'd1}, '{PROP_FACT, 31'd2},
    '{PROP_FACT, 31'd479001600}, '{PROP_FACT, 31'd479001599},
    '{PROP_FACT, 31'd1932053504}   // 13! wrapped to 31 bits
  };

  integer_property_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint fib_term(int n);
    longint a, b, t;
    a = 0;
    b = 1;
    repeat (n) begin
      t = a + b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Bias toward sequence members and their neighbors so every property sees hits.
  function automatic logic [30:0] pick_value();
    longint c;
    int     k;
    int     r;
    int     d;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: c = $urandom & 32'h7FFF_FFFF;
      2: c = $urandom_range(0, 64);
      3: c = fib_term($urandom_range(0, 46));
      4: begin
        r = $urandom_range(0, 46340);
        c = longint'(r) * r;
      end
      5: begin
        r = $urandom_range(0, 1290);
        c = longint'(r) * r * r;
      end
      6: begin
        c = 1;
        r = $urandom_range(0, 13);
        for (int n = 1; n <= r; n++) c = c * n;
        c = c & 64'h7FFF_FFFF;
      end
      7: c = longint'(VALUE_MAX) - $urandom_range(0, 16);
      default: c = $urandom & ((33'h1 << $urandom_range(1, 31)) - 1);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      d = $urandom_range(0, 2);
      c = c + d - 1;
    end
    if (c < 0) c = 0;
    if (c > longint'(VALUE_MAX)) c = longint'(VALUE_MAX);
    return c[30:0];
  endfunction

  task automatic send_item(logic [30:0] v, logic last);
    int gap;
    gap = tx_gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(v, last);
  endtask

  // Register writes only once the block has drained.
  task automatic program_property(prop_t p);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.prop = p;
  endtask

  // output side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_stalls_on) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic last;
    prop_t p;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = PROP_FIB;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    stall_left    = 0;
    cycle_count   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      if (i == 0 || probes[i].prop != probes[i-1].prop) program_property(probes[i].prop);
      last = (i == 22) || (probes[i+1].prop != probes[i].prop);
      send_item(probes[i].value, last);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      p = (ph < 4) ? prop_t'(3 - ph) : prop_t'($urandom_range(0, 3));
      program_property(p);
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches of back-to-back traffic inside a phase
        if (n % 35 == 0) tx_gaps_on = ($urandom_range(0, 2) != 0);
        send_item(pick_value(), $urandom_range(0, 7) == 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_cmp.sv
hw/rtl/ipc_core.sv
hw/rtl/integer_property_classifier.sv
hw/rtl/ipc_checker.sv
verif/tb_top.sv
